[rtl/core/waypoint_heading_quaternion_macros.svh]
// Assertion helpers shared by the waypoint heading RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef WAYPOINT_HEADING_QUATERNION_MACROS_SVH
`define WAYPOINT_HEADING_QUATERNION_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/whq_pkg.sv]
package whq_pkg;

    // Beat and field widths
    localparam int POS_W   = 32;
    localparam int Q_W     = 16;
    localparam int DIF_W   = 33;
    localparam int YAW_W   = 15;
    localparam int TDATA_W = 3 * POS_W + 4 * Q_W;

    // CORDIC datapath: x/y hold a 33-bit step scaled by 2^16 plus gain growth
    localparam int XY_W    = 52;
    // Angle accumulator, Q3.24 with headroom
    localparam int ANG_W   = 29;
    localparam int ATAN_IW = 5;

    // Configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] CFG_YAW_MODE  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FIXED_YAW = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_MIN_STEP  = 2'd2;

    localparam logic [1:0] MODE_KEEP  = 2'd0;
    localparam logic [1:0] MODE_FIXED = 2'd1;
    localparam logic [1:0] MODE_HEAD  = 2'd2;

    localparam logic [CFG_DW-1:0] MIN_STEP_RST = 16'd66;

    // Angle and gain constants
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 29'sd26353589;
    localparam logic signed [ANG_W-1:0] ANG_PI      = 29'sd52707179;
    localparam logic signed [XY_W-1:0]  GAIN_Q30    = 52'sd652032874;
    localparam logic signed [Q_W-1:0]   Q_ONE       = 16'sd16384;

    typedef logic signed [XY_W-1:0]  t_xy;
    typedef logic signed [ANG_W-1:0] t_ang;
    typedef logic signed [Q_W-1:0]   t_q;

    // Request to the shared CORDIC engine
    typedef struct packed {
        logic start;
        logic vec;      // 1: vectoring (atan2), 0: rotation (sin/cos)
    } t_cor_cmd;

    typedef struct packed {
        logic busy;
        logic done;     // one-cycle pulse after the last micro-rotation
    } t_cor_sts;

    // atan(2^-i) in Q3.24
    function automatic t_ang atan_q24(input logic [ATAN_IW-1:0] idx);
        case (idx)
            5'd0:    atan_q24 = 29'sd13176795;
            5'd1:    atan_q24 = 29'sd7778716;
            5'd2:    atan_q24 = 29'sd4110060;
            5'd3:    atan_q24 = 29'sd2086331;
            5'd4:    atan_q24 = 29'sd1047214;
            5'd5:    atan_q24 = 29'sd524117;
            5'd6:    atan_q24 = 29'sd262123;
            5'd7:    atan_q24 = 29'sd131069;
            5'd8:    atan_q24 = 29'sd65536;
            5'd9:    atan_q24 = 29'sd32768;
            5'd10:   atan_q24 = 29'sd16384;
            5'd11:   atan_q24 = 29'sd8192;
            5'd12:   atan_q24 = 29'sd4096;
            5'd13:   atan_q24 = 29'sd2048;
            5'd14:   atan_q24 = 29'sd1024;
            5'd15:   atan_q24 = 29'sd512;
            5'd16:   atan_q24 = 29'sd256;
            5'd17:   atan_q24 = 29'sd128;
            5'd18:   atan_q24 = 29'sd64;
            5'd19:   atan_q24 = 29'sd32;
            5'd20:   atan_q24 = 29'sd16;
            5'd21:   atan_q24 = 29'sd8;
            5'd22:   atan_q24 = 29'sd4;
            5'd23:   atan_q24 = 29'sd2;
            default: atan_q24 = '0;
        endcase
    endfunction

endpackage

[rtl/core/waypoint_heading_quaternion.sv]
// Channel   | Dir | Beat content (low bits first)
// s_axis    | in  | tdata: pos_x, pos_y, pos_z, quat_in_x/y/z/w; tlast: path_end
// m_axis    | out | tdata: out_x, out_y, out_z, orient_x/y/z/w; tlast: final_out
// cfg       | in  | index: 0 yaw_mode, 1 fixed_yaw_angle, 2 min_step; data: value
//
// One waypoint at a time; s_axis_tready is high only while the sequencer idles.
// Keep mode passes the beat through. Fixed mode runs the sin/cos rotation on
// the single shared CORDIC engine; heading with a held point uses it for atan2
// (skipped for a zero or short step) and then sin/cos, one micro-rotation a cycle.
// Synchronous active-low reset; no clearing pass. A stalled m_axis holds the
// result register and the sequencer waits at its emit step.
`include "waypoint_heading_quaternion_macros.svh"

module waypoint_heading_quaternion #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // pos_x, pos_y, pos_z, quat_in_x, quat_in_y, quat_in_z, quat_in_w
    input  logic [whq_pkg::TDATA_W-1:0]  s_axis_tdata,
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // out_x, out_y, out_z, orient_x, orient_y, orient_z, orient_w
    output logic [whq_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tlast,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [whq_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [whq_pkg::CFG_DW-1:0]   i_cfg_data
);
    import whq_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DIFF      = 4'd1;
    localparam logic [3:0] S_CHK       = 4'd2;
    localparam logic [3:0] S_SQ        = 4'd3;
    localparam logic [3:0] S_SQCMP     = 4'd4;
    localparam logic [3:0] S_VPRE      = 4'd5;
    localparam logic [3:0] S_VEC       = 4'd6;
    localparam logic [3:0] S_QPRE      = 4'd7;
    localparam logic [3:0] S_ROT       = 4'd8;
    localparam logic [3:0] S_EMIT_HELD = 4'd9;
    localparam logic [3:0] S_EMIT_CUR  = 4'd10;
    localparam logic [3:0] S_EMIT_PASS = 4'd11;

    localparam logic [1:0] SQ_LAST = 2'd2;

    // Control state
    logic [3:0]              r_state;
    logic [3:0]              n_state;
    logic [1:0]              r_sq_cnt;
    logic                    r_held_valid;
    logic [POS_W-1:0]        r_held_x;
    logic [POS_W-1:0]        r_held_y;
    logic [POS_W-1:0]        r_held_z;
    logic                    r_out_valid;
    logic [1:0]              r_yaw_mode;
    logic signed [YAW_W-1:0] r_fixed_yaw;
    logic [CFG_DW-1:0]       r_min_step;

    // Item datapath
    logic [TDATA_W-1:0]      r_in;
    logic                    r_fin;
    logic                    r_head;
    logic signed [YAW_W-1:0] r_yaw;
    logic signed [DIF_W-1:0] r_dx;
    logic signed [DIF_W-1:0] r_dy;
    logic [15:0]             r_sq_a;
    logic [15:0]             r_sq_b;
    logic signed [33:0]      r_acc;
    logic                    r_neg;
    t_q                      r_qs;
    t_q                      r_qc;
    logic [TDATA_W-1:0]      r_out_data;
    logic                    r_out_last;

    logic               in_acc;
    logic               slot_free;
    logic               out_load;
    logic [TDATA_W-1:0] n_out_data;
    logic               n_out_last;
    logic [DIF_W-1:0]   ax;
    logic [DIF_W-1:0]   ay;
    logic               dxy_zero;
    logic               near;
    logic [15:0]        sq_op;
    logic [31:0]        sq_prod;
    logic               sq_short;
    t_xy                dxs;
    t_xy                dys;
    t_ang               h;
    t_ang               h_fold;
    logic               h_neg;
    t_ang               z_rnd;
    t_q                 q_s;
    t_q                 q_c;

    t_cor_cmd cor_cmd;
    t_cor_sts cor_sts;
    t_xy      cor_x_in;
    t_xy      cor_y_in;
    t_ang     cor_z_in;
    t_xy      cor_x;
    t_xy      cor_y;
    t_ang     cor_z;

    // Round half up from Q2.30 to Q2.14 and clamp to +/-1.0
    function automatic t_q round_sat(input t_xy v);
        t_xy                    r;
        logic signed [XY_W-17:0] q;
        r = v + XY_W'(32768);
        q = r[XY_W-1:16];
        if (q > Q_ONE) begin
            round_sat = Q_ONE;
        end else if (q < -Q_ONE) begin
            round_sat = -Q_ONE;
        end else begin
            round_sat = Q_W'(q);
        end
    endfunction

    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign slot_free     = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Step magnitude and short-step tests
    always_comb begin
        ax       = r_dx[DIF_W-1] ? DIF_W'(-r_dx) : DIF_W'(r_dx);
        ay       = r_dy[DIF_W-1] ? DIF_W'(-r_dy) : DIF_W'(r_dy);
        dxy_zero = (r_dx == '0) && (r_dy == '0);
        near     = (ax < {{(DIF_W-CFG_DW){1'b0}}, r_min_step})
                && (ay < {{(DIF_W-CFG_DW){1'b0}}, r_min_step});
        case (r_sq_cnt)
            2'd0:    sq_op = r_min_step;
            2'd1:    sq_op = r_sq_a;
            default: sq_op = r_sq_b;
        endcase
        sq_prod  = sq_op * sq_op;
        sq_short = !r_acc[33] && (r_acc != '0);
    end

    // Engine operands: quarter-turn prerotation or folded half angle
    always_comb begin
        dxs    = {{(XY_W-DIF_W-16){r_dx[DIF_W-1]}}, r_dx, 16'b0};
        dys    = {{(XY_W-DIF_W-16){r_dy[DIF_W-1]}}, r_dy, 16'b0};
        h      = {{(ANG_W-YAW_W-11){r_yaw[YAW_W-1]}}, r_yaw, 11'b0};
        h_neg  = 1'b0;
        h_fold = h;
        if (h > ANG_HALF_PI) begin
            h_fold = h - ANG_PI;
            h_neg  = 1'b1;
        end else if (h < -ANG_HALF_PI) begin
            h_fold = h + ANG_PI;
            h_neg  = 1'b1;
        end

        cor_cmd.start = (r_state == S_VPRE) || (r_state == S_QPRE);
        cor_cmd.vec   = (r_state == S_VPRE);
        if (r_state == S_VPRE) begin
            if (r_dx[DIF_W-1]) begin
                if (!r_dy[DIF_W-1]) begin
                    cor_x_in = dys;
                    cor_y_in = -dxs;
                    cor_z_in = ANG_HALF_PI;
                end else begin
                    cor_x_in = -dys;
                    cor_y_in = dxs;
                    cor_z_in = -ANG_HALF_PI;
                end
            end else begin
                cor_x_in = dxs;
                cor_y_in = dys;
                cor_z_in = '0;
            end
        end else begin
            cor_x_in = GAIN_Q30;
            cor_y_in = '0;
            cor_z_in = h_fold;
        end
    end

    // Engine results
    always_comb begin
        z_rnd = cor_z + ANG_W'(2048);
        q_c   = round_sat(cor_x);
        q_s   = round_sat(cor_y);
    end

    whq_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cor_cmd),
        .i_x    (cor_x_in),
        .i_y    (cor_y_in),
        .i_z    (cor_z_in),
        .o_sts  (cor_sts),
        .o_x    (cor_x),
        .o_y    (cor_y),
        .o_z    (cor_z)
    );

    // Sequencer
    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (r_held_valid) begin
                        n_state = S_DIFF;
                    end else if (r_yaw_mode == MODE_HEAD) begin
                        n_state = s_axis_tlast ? S_QPRE : S_IDLE;
                    end else if (r_yaw_mode == MODE_FIXED) begin
                        n_state = S_QPRE;
                    end else begin
                        n_state = S_EMIT_PASS;
                    end
                end
            end
            S_DIFF: n_state = S_CHK;
            S_CHK: begin
                if (dxy_zero) begin
                    n_state = S_QPRE;
                end else if (near) begin
                    n_state = S_SQ;
                end else begin
                    n_state = S_VPRE;
                end
            end
            S_SQ: begin
                if (r_sq_cnt == SQ_LAST) begin
                    n_state = S_SQCMP;
                end
            end
            S_SQCMP: n_state = sq_short ? S_QPRE : S_VPRE;
            S_VPRE:  n_state = S_VEC;
            S_VEC: begin
                if (cor_sts.done) begin
                    n_state = S_QPRE;
                end
            end
            S_QPRE: n_state = S_ROT;
            S_ROT: begin
                if (cor_sts.done) begin
                    n_state = r_head ? S_EMIT_HELD : S_EMIT_CUR;
                end
            end
            S_EMIT_HELD: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    if (r_yaw_mode == MODE_HEAD) begin
                        n_state = r_fin ? S_EMIT_CUR : S_IDLE;
                    end else if (r_yaw_mode == MODE_FIXED) begin
                        n_state = S_QPRE;
                    end else begin
                        n_state = S_EMIT_PASS;
                    end
                end
            end
            S_EMIT_CUR, S_EMIT_PASS: begin
                if (slot_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result beat
    always_comb begin
        n_out_data = r_in;
        n_out_last = r_fin;
        if (r_state == S_EMIT_HELD) begin
            n_out_data = {r_qc, r_qs, {(2*Q_W){1'b0}}, r_held_z, r_held_y, r_held_x};
            n_out_last = 1'b0;
        end else if (r_state == S_EMIT_CUR) begin
            n_out_data = {r_qc, r_qs, {(2*Q_W){1'b0}}, r_in[3*POS_W-1:0]};
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_sq_cnt     <= '0;
            r_held_valid <= 1'b0;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_held_z     <= '0;
            r_out_valid  <= 1'b0;
            r_yaw_mode   <= MODE_KEEP;
            r_fixed_yaw  <= '0;
            r_min_step   <= MIN_STEP_RST;
        end else begin
            r_state <= n_state;

            if (r_state == S_CHK) begin
                r_sq_cnt <= '0;
            end else if (r_state == S_SQ) begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end

            // Hold back a point in heading mode
            if (in_acc && !r_held_valid && r_yaw_mode == MODE_HEAD && !s_axis_tlast) begin
                r_held_valid <= 1'b1;
                r_held_x     <= s_axis_tdata[POS_W-1:0];
                r_held_y     <= s_axis_tdata[2*POS_W-1:POS_W];
                r_held_z     <= s_axis_tdata[3*POS_W-1:2*POS_W];
            end else if (r_state == S_EMIT_HELD && slot_free) begin
                r_held_valid <= 1'b0;
                if (r_yaw_mode == MODE_HEAD && !r_fin) begin
                    r_held_valid <= 1'b1;
                    r_held_x     <= r_in[POS_W-1:0];
                    r_held_y     <= r_in[2*POS_W-1:POS_W];
                    r_held_z     <= r_in[3*POS_W-1:2*POS_W];
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            // Register writes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_YAW_MODE:  r_yaw_mode  <= i_cfg_data[1:0];
                    CFG_FIXED_YAW: r_fixed_yaw <= i_cfg_data[YAW_W-1:0];
                    CFG_MIN_STEP:  r_min_step  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in   <= s_axis_tdata;
            r_fin  <= s_axis_tlast;
            r_head <= r_held_valid;
            r_yaw  <= (r_yaw_mode == MODE_FIXED) ? r_fixed_yaw : '0;
        end

        if (r_state == S_DIFF) begin
            r_dx <= DIF_W'($signed(r_in[POS_W-1:0])) - DIF_W'($signed(r_held_x));
            r_dy <= DIF_W'($signed(r_in[2*POS_W-1:POS_W])) - DIF_W'($signed(r_held_y));
        end

        if (r_state == S_CHK) begin
            r_sq_a <= ax[15:0];
            r_sq_b <= ay[15:0];
            r_yaw  <= '0;
        end

        // min_step^2 - dx^2 - dy^2, one square a cycle
        if (r_state == S_SQ) begin
            if (r_sq_cnt == 2'd0) begin
                r_acc <= {2'b00, sq_prod};
            end else begin
                r_acc <= r_acc - {2'b00, sq_prod};
            end
        end

        if (r_state == S_VEC && cor_sts.done) begin
            r_yaw <= z_rnd[YAW_W+11:12];
        end

        if (r_state == S_QPRE) begin
            r_neg <= h_neg;
        end

        if (r_state == S_ROT && cor_sts.done) begin
            r_qs <= r_neg ? -q_s : q_s;
            r_qc <= r_neg ? -q_c : q_c;
        end

        if (r_state == S_EMIT_HELD && slot_free) begin
            r_head <= 1'b0;
            r_yaw  <= r_fixed_yaw;
        end

        if (out_load) begin
            r_out_data <= n_out_data;
            r_out_last <= n_out_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `ASSERT_IMPL(a_engine_live, i_clk, i_rst_n, r_state == S_VEC || r_state == S_ROT, cor_sts.busy || cor_sts.done)
    `ASSERT_IMPL(a_held_emit, i_clk, i_rst_n, r_state == S_EMIT_HELD, r_held_valid)
    `ASSERT_IMPL(a_quat_range, i_clk, i_rst_n, r_state == S_EMIT_HELD || r_state == S_EMIT_CUR, r_qs <= Q_ONE && r_qs >= -Q_ONE && r_qc <= Q_ONE && r_qc >= -Q_ONE)
    `ASSERT_NEXT(a_held_clear, i_clk, i_rst_n, r_state == S_EMIT_HELD && slot_free && r_yaw_mode != MODE_HEAD, !r_held_valid)

endmodule

[rtl/core/whq_cordic.sv]
`include "waypoint_heading_quaternion_macros.svh"

// Shared CORDIC engine: one micro-rotation per cycle, vectoring or rotation.
module whq_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  whq_pkg::t_cor_cmd i_cmd,
    input  whq_pkg::t_xy      i_x,
    input  whq_pkg::t_xy      i_y,
    input  whq_pkg::t_ang     i_z,
    output whq_pkg::t_cor_sts o_sts,
    output whq_pkg::t_xy      o_x,
    output whq_pkg::t_xy      o_y,
    output whq_pkg::t_ang     o_z
);
    import whq_pkg::*;

    localparam int CW = $clog2(CORDIC_STEPS);
    localparam logic [CW-1:0] LAST = CW'(CORDIC_STEPS - 1);

    logic          r_busy;
    logic          r_done;
    logic          r_vec;
    logic [CW-1:0] r_cnt;
    t_xy           r_x;
    t_xy           r_y;
    t_ang          r_z;

    t_xy  xs;
    t_xy  ys;
    t_ang atan_i;
    logic plus;

    // One micro-rotation: plus means x += y>>i, y -= x>>i, z += atan
    always_comb begin
        xs     = r_x >>> r_cnt;
        ys     = r_y >>> r_cnt;
        atan_i = atan_q24(ATAN_IW'(r_cnt));
        plus   = r_vec ? (!r_y[XY_W-1] && (r_y != '0)) : r_z[ANG_W-1];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_vec <= i_cmd.vec;
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_z;
        end else if (r_busy) begin
            if (plus) begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + atan_i;
            end else begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - atan_i;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_x        = r_x;
    assign o_y        = r_y;
    assign o_z        = r_z;

    `ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, i_cmd.start, !r_busy)
    `ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_busy && r_cnt == LAST, r_done && !r_busy)
    `ASSERT_NEXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done)
    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, r_busy, r_cnt <= LAST)

endmodule
